/* hw/rtl/mpd_pkg.sv */
// ----------------------------------------------------------------------------
// mpd_pkg
// Shared types and constants of the mercator point distance block.
// ----------------------------------------------------------------------------
`default_nettype none

package mpd_pkg;

  localparam int COORD_BITS_DEF     = 32;
  localparam int COEF_FRAC_BITS_DEF = 24;
  localparam int GUARD_BITS         = 15;

  localparam int CIRC_W     = 36;
  localparam int COEF_W     = 32;
  localparam int DIST_W     = 37;
  localparam int POLY_W     = 35;
  localparam int AVF_W      = 34;
  localparam int ROOT_W     = 64;
  localparam int SQ_W       = 2 * ROOT_W;
  localparam int DEN_W      = 64;
  localparam int NUM_W      = CIRC_W + ROOT_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 36;
  localparam int OUT_DATA_W = ((DIST_W + 7) / 8) * 8;

  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

  localparam logic [CIRC_W-1:0]        CIRC_RST     = 36'd40075016686;
  localparam logic signed [COEF_W-1:0] SCALE_C0_RST = 32'sd16777216;
  localparam logic signed [COEF_W-1:0] SCALE_C2_RST = 32'sd325977162;
  localparam logic signed [COEF_W-1:0] SCALE_C4_RST = 32'sd1245258622;
  localparam logic signed [COEF_W-1:0] VERT_C0_RST  = 32'sd16664903;
  localparam logic signed [COEF_W-1:0] VERT_C2_RST  = 32'sd3131150;
  localparam logic signed [COEF_W-1:0] VERT_C4_RST  = -32'sd24412619;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CIRCUMFERENCE = 3'd0,
    REG_SCALE_C0      = 3'd1,
    REG_SCALE_C2      = 3'd2,
    REG_SCALE_C4      = 3'd3,
    REG_VERT_C0       = 3'd4,
    REG_VERT_C2       = 3'd5,
    REG_VERT_C4       = 3'd6
  } cfg_reg_e;

  typedef struct packed {
    logic              sat;
    logic [DIST_W-1:0] dist_mm;
  } result_t;

endpackage

`default_nettype wire

/* hw/rtl/mpd_isqrt.sv */
// ----------------------------------------------------------------------------
// mpd_isqrt
// Pipelined integer square root, one root bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_isqrt #(
  parameter int IN_W   = mpd_pkg::SQ_W,
  parameter int SIDE_W = 1
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire logic                vld_i,
  input  wire logic [IN_W-1:0]     rad_i,
  input  wire logic [SIDE_W-1:0]   side_i,
  output logic                     vld_o,
  output logic [IN_W/2-1:0]        root_o,
  output logic [SIDE_W-1:0]        side_o
);

  localparam int RT_W  = IN_W / 2;
  localparam int REM_W = RT_W + 3;

  logic [RT_W-1:0]              vld_q;
  logic [RT_W-1:0]              vin;
  logic [REM_W-1:0]             rem_q  [RT_W];
  logic [REM_W-1:0]             rem_d  [RT_W];
  logic [REM_W-1:0]             rin    [RT_W];
  logic [RT_W-1:0]              root_q [RT_W];
  logic [RT_W-1:0]              root_d [RT_W];
  logic [RT_W-1:0]              oin    [RT_W];
  logic [IN_W-1:0]              rad_q  [RT_W];
  logic [IN_W-1:0]              rad_d  [RT_W];
  logic [IN_W-1:0]              nin    [RT_W];
  logic [SIDE_W-1:0]            side_q [RT_W];
  logic [SIDE_W-1:0]            sin    [RT_W];

  always_comb begin
    logic [REM_W-1:0] rsh;
    logic [REM_W-1:0] trial;
    logic             ge;
    vin[0] = vld_i;
    rin[0] = '0;
    oin[0] = '0;
    nin[0] = rad_i;
    sin[0] = side_i;
    for (int k = 1; k < RT_W; k++) begin
      vin[k] = vld_q[k-1];
      rin[k] = rem_q[k-1];
      oin[k] = root_q[k-1];
      nin[k] = rad_q[k-1];
      sin[k] = side_q[k-1];
    end
    for (int k = 0; k < RT_W; k++) begin
      rsh       = {rin[k][REM_W-3:0], nin[k][IN_W-1 -: 2]};
      trial     = {1'b0, oin[k], 2'b01};
      ge        = (rsh >= trial);
      rem_d[k]  = ge ? (rsh - trial) : rsh;
      root_d[k] = {oin[k][RT_W-2:0], ge};
      rad_d[k]  = nin[k] << 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      rad_q  <= rad_d;
      side_q <= sin;
    end
  end

  assign vld_o  = vld_q[RT_W-1];
  assign root_o = root_q[RT_W-1];
  assign side_o = side_q[RT_W-1];

endmodule

`default_nettype wire

/* hw/rtl/mpd_div.sv */
// ----------------------------------------------------------------------------
// mpd_div
// Pipelined restoring divider, one quotient bit per register stage, with an
// overflow flag for quotient bits above the kept width.
// ----------------------------------------------------------------------------
`default_nettype none

module mpd_div #(
  parameter int NUM_W  = mpd_pkg::NUM_W,
  parameter int DEN_W  = mpd_pkg::DEN_W,
  parameter int QUO_W  = mpd_pkg::DIST_W,
  parameter int SIDE_W = 1
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              en_i,
  input  wire logic              vld_i,
  input  wire logic [NUM_W-1:0]  num_i,
  input  wire logic [DEN_W-1:0]  den_i,
  input  wire logic [SIDE_W-1:0] side_i,
  output logic                   vld_o,
  output logic [QUO_W-1:0]       quo_o,
  output logic                   ovf_o,
  output logic [SIDE_W-1:0]      side_o
);

  logic [NUM_W-1:0]  vld_q;
  logic [NUM_W-1:0]  vin;
  logic [NUM_W-1:0]  ovf_q;
  logic [NUM_W-1:0]  ovf_d;
  logic [NUM_W-1:0]  fin;
  logic [DEN_W-1:0]  rem_q  [NUM_W];
  logic [DEN_W-1:0]  rem_d  [NUM_W];
  logic [DEN_W-1:0]  rin    [NUM_W];
  logic [DEN_W-1:0]  den_q  [NUM_W];
  logic [DEN_W-1:0]  din    [NUM_W];
  logic [NUM_W-1:0]  num_q  [NUM_W];
  logic [NUM_W-1:0]  num_d  [NUM_W];
  logic [NUM_W-1:0]  nin    [NUM_W];
  logic [QUO_W-1:0]  quo_q  [NUM_W];
  logic [QUO_W-1:0]  quo_d  [NUM_W];
  logic [QUO_W-1:0]  qin    [NUM_W];
  logic [SIDE_W-1:0] side_q [NUM_W];
  logic [SIDE_W-1:0] sin    [NUM_W];

  always_comb begin
    logic [DEN_W-1:0] rsh;
    logic             ge;
    vin[0] = vld_i;
    fin[0] = 1'b0;
    rin[0] = '0;
    din[0] = den_i;
    nin[0] = num_i;
    qin[0] = '0;
    sin[0] = side_i;
    for (int k = 1; k < NUM_W; k++) begin
      vin[k] = vld_q[k-1];
      fin[k] = ovf_q[k-1];
      rin[k] = rem_q[k-1];
      din[k] = den_q[k-1];
      nin[k] = num_q[k-1];
      qin[k] = quo_q[k-1];
      sin[k] = side_q[k-1];
    end
    for (int k = 0; k < NUM_W; k++) begin
      // The partial remainder wraps at its width when shifted.
      rsh      = {rin[k][DEN_W-2:0], nin[k][NUM_W-1]};
      ge       = (rsh >= din[k]);
      rem_d[k] = ge ? (rsh - din[k]) : rsh;
      quo_d[k] = {qin[k][QUO_W-2:0], ge};
      ovf_d[k] = fin[k] | (ge & ((NUM_W - 1 - k) >= QUO_W));
      num_d[k] = nin[k] << 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vin;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ovf_q  <= ovf_d;
      rem_q  <= rem_d;
      den_q  <= din;
      num_q  <= num_d;
      quo_q  <= quo_d;
      side_q <= sin;
    end
  end

  assign vld_o  = vld_q[NUM_W-1];
  assign quo_o  = quo_q[NUM_W-1];
  assign ovf_o  = ovf_q[NUM_W-1];
  assign side_o = side_q[NUM_W-1];

endmodule

`default_nettype wire

/* hw/rtl/mercator_point_distance.sv */
// ----------------------------------------------------------------------------
// mercator_point_distance
// Approximate ground distance in millimeters between two points given as
// unsigned fractions of a web-mercator map.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  first_x, first_y,
//                                                    second_x, second_y
//  m_axis    out        m_axis_tvalid/m_axis_tready  distance_mm, saturated
//  cfg       in         cfg_valid_i/cfg_ready_o      register index, data
//
//  One transaction is taken per cycle while the pipeline is not frozen, and
//  its result is written to the output buffer. The square root (64 stages)
//  and the divider (100 stages) each produce one bit per stage.
//  Reset clears the valid bits and the output buffer count, and loads the configuration registers with their defaults.
//  The pipeline freezes only when the two-entry output buffer is full and
//  the consumer does not take a transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module mercator_point_distance #(
  parameter int COORD_BITS     = mpd_pkg::COORD_BITS_DEF,
  parameter int COEF_FRAC_BITS = mpd_pkg::COEF_FRAC_BITS_DEF
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid,
  output logic                                         s_axis_tready,
  // first_x, first_y, second_x, second_y
  input  wire logic [((4*COORD_BITS+7)/8)*8-1:0]       s_axis_tdata,
  output logic                                         m_axis_tvalid,
  input  wire logic                                    m_axis_tready,
  // distance_mm
  output logic [mpd_pkg::OUT_DATA_W-1:0]               m_axis_tdata,
  // saturated
  output logic                                         m_axis_tuser,
  input  wire logic                                    cfg_valid_i,
  output logic                                         cfg_ready_o,
  input  wire logic [mpd_pkg::CFG_IDX_W-1:0]           cfg_index_i,
  input  wire logic [mpd_pkg::CFG_DATA_W-1:0]          cfg_data_i
);

  localparam int C      = COORD_BITS;
  localparam int F      = COEF_FRAC_BITS;
  localparam int ZA_W   = F + 1;
  localparam int ZS     = C + 1 - F;
  localparam int ZR     = (ZS > 0) ? ZS : 0;
  localparam int ZL     = (ZS < 0) ? -ZS : 0;
  localparam int Q_SR   = (C > 32) ? C - 32 : 0;
  localparam int Q_SL   = (C < 32) ? 32 - C : 0;
  localparam int PP_W   = mpd_pkg::COEF_W + ZA_W + 1;
  localparam int PW     = mpd_pkg::POLY_W;
  localparam int AVF_W  = mpd_pkg::AVF_W;
  localparam int DYG_SH = F - mpd_pkg::GUARD_BITS;
  localparam int DYG_W  = 64 - DYG_SH;
  localparam int A1_W   = DYG_W - 32;
  localparam int DEN_SH = 32 + mpd_pkg::GUARD_BITS - F;
  localparam int SQ_W   = mpd_pkg::SQ_W;
  localparam int RT_W   = mpd_pkg::ROOT_W;
  localparam int DEN_W  = mpd_pkg::DEN_W;
  localparam int NUM_W  = mpd_pkg::NUM_W;
  localparam int CW     = mpd_pkg::CIRC_W;
  localparam logic [C:0] HALF2 = {1'b1, {C{1'b0}}};

  // Configuration registers.
  logic [CW-1:0]                        circ_q;
  logic signed [mpd_pkg::COEF_W-1:0]    sc0_q, sc2_q, sc4_q, vc0_q, vc2_q, vc4_q;

  // Pipeline control.
  logic en;
  logic [7:0] v_q;

  // Stage 1.
  logic [C-1:0] x1, y1, x2, y2, adx_d, ady_d;
  logic [C:0]   ysum, azh_d;
  logic [C-1:0] adx1_q, ady1_q;
  logic [C:0]   azh1_q;
  // Stage 2.
  logic [ZA_W-1:0]   za;
  logic [2*ZA_W-1:0] zsq;
  logic [ZA_W-1:0]   z2_2q;
  logic [31:0]       adx2_q, ady2_q;
  // Stage 3.
  logic [2*ZA_W-1:0] z4sq;
  logic [ZA_W-1:0]   z2_3q, z4_3q;
  logic [31:0]       adx3_q, ady3_q;
  // Stage 4.
  logic signed [ZA_W:0]   z2s, z4s;
  logic signed [PP_W-1:0] pv2_q, pv4_q, ps2_q, ps4_q;
  logic [31:0]            adx4_q, ady4_q;
  // Stage 5.
  logic signed [PW-1:0] vf_q, sf_q;
  logic [31:0]          adx5_q, ady5_q;
  // Stage 6.
  logic signed [PW-1:0] vneg;
  logic [AVF_W-1:0]     avf;
  logic [63:0]          dyp6_q;
  logic [31:0]          adx6_q;
  logic [DEN_W-1:0]     den6_q;
  logic                 np6_q;
  // Stage 7.
  logic [DYG_W-1:0]     dyg;
  logic [63:0]          p00_q, xx_q;
  logic [A1_W+31:0]     p10_q;
  logic [2*A1_W-1:0]    p11_q;
  logic [DEN_W-1:0]     den7_q;
  logic                 np7_q;
  // Stage 8.
  logic [SQ_W-1:0]      sq_q;
  logic [DEN_W-1:0]     den8_q;
  logic                 np8_q;
  // Square root.
  logic                 rt_vld;
  logic [RT_W-1:0]      root;
  logic [DEN_W:0]       rt_side;
  // Numerator product stages.
  logic                 m1_vld_q, m2_vld_q;
  logic [CW+31:0]       mlo_q, mhi_q;
  logic [DEN_W-1:0]     den_m1_q, den_m2_q;
  logic                 np_m1_q, np_m2_q;
  logic [NUM_W-1:0]     num_q;
  // Divider.
  logic                        dv_vld;
  logic [mpd_pkg::DIST_W-1:0]  quo;
  logic                        ovf;
  logic                        dv_np;
  // Output buffer.
  mpd_pkg::result_t res, b0_q, b0_d, b1_q, b1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop, push;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      circ_q <= mpd_pkg::CIRC_RST;
      sc0_q  <= mpd_pkg::SCALE_C0_RST;
      sc2_q  <= mpd_pkg::SCALE_C2_RST;
      sc4_q  <= mpd_pkg::SCALE_C4_RST;
      vc0_q  <= mpd_pkg::VERT_C0_RST;
      vc2_q  <= mpd_pkg::VERT_C2_RST;
      vc4_q  <= mpd_pkg::VERT_C4_RST;
    end else if (cfg_valid_i) begin
      unique case (mpd_pkg::cfg_reg_e'(cfg_index_i))
        mpd_pkg::REG_CIRCUMFERENCE: circ_q <= cfg_data_i[CW-1:0];
        mpd_pkg::REG_SCALE_C0:      sc0_q  <= signed'(cfg_data_i[31:0]);
        mpd_pkg::REG_SCALE_C2:      sc2_q  <= signed'(cfg_data_i[31:0]);
        mpd_pkg::REG_SCALE_C4:      sc4_q  <= signed'(cfg_data_i[31:0]);
        mpd_pkg::REG_VERT_C0:       vc0_q  <= signed'(cfg_data_i[31:0]);
        mpd_pkg::REG_VERT_C2:       vc2_q  <= signed'(cfg_data_i[31:0]);
        mpd_pkg::REG_VERT_C4:       vc4_q  <= signed'(cfg_data_i[31:0]);
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Front stages: differences, latitude term, polynomials, squares
  // --------------------------------------------------------------------------
  assign s_axis_tready = en;

  always_comb begin
    x1    = s_axis_tdata[C-1:0];
    y1    = s_axis_tdata[2*C-1:C];
    x2    = s_axis_tdata[3*C-1:2*C];
    y2    = s_axis_tdata[4*C-1:3*C];
    adx_d = (x1 >= x2) ? (x1 - x2) : (x2 - x1);
    ady_d = (y1 >= y2) ? (y1 - y2) : (y2 - y1);
    ysum  = {1'b0, y1} + {1'b0, y2};
    azh_d = (ysum >= HALF2) ? (ysum - HALF2) : (HALF2 - ysum);

    za    = ZA_W'((64'(azh1_q) >> ZR) << ZL);
    zsq   = (2*ZA_W)'(za) * (2*ZA_W)'(za);
    z4sq  = (2*ZA_W)'(z2_2q) * (2*ZA_W)'(z2_2q);

    z2s   = signed'({1'b0, z2_3q});
    z4s   = signed'({1'b0, z4_3q});

    vneg  = -vf_q;
    avf   = AVF_W'(vf_q[PW-1] ? vneg : vf_q);

    dyg   = DYG_W'(dyp6_q >> DYG_SH);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[6:0], s_axis_tvalid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      adx1_q <= adx_d;
      ady1_q <= ady_d;
      azh1_q <= azh_d;

      z2_2q  <= ZA_W'(zsq >> F);
      adx2_q <= 32'((64'(adx1_q) >> Q_SR) << Q_SL);
      ady2_q <= 32'((64'(ady1_q) >> Q_SR) << Q_SL);

      z2_3q  <= z2_2q;
      z4_3q  <= ZA_W'(z4sq >> F);
      adx3_q <= adx2_q;
      ady3_q <= ady2_q;

      pv2_q  <= PP_W'(vc2_q) * PP_W'(z2s);
      pv4_q  <= PP_W'(vc4_q) * PP_W'(z4s);
      ps2_q  <= PP_W'(sc2_q) * PP_W'(z2s);
      ps4_q  <= PP_W'(sc4_q) * PP_W'(z4s);
      adx4_q <= adx3_q;
      ady4_q <= ady3_q;

      vf_q   <= PW'(vc0_q) + PW'(pv2_q >>> F) + PW'(pv4_q >>> F);
      sf_q   <= PW'(sc0_q) + PW'(ps2_q >>> F) + PW'(ps4_q >>> F);
      adx5_q <= adx4_q;
      ady5_q <= ady4_q;

      dyp6_q <= 64'(66'(ady5_q) * 66'(avf));
      adx6_q <= adx5_q;
      den6_q <= DEN_W'(sf_q) << DEN_SH;
      np6_q  <= sf_q[PW-1] | (sf_q == '0);

      p00_q  <= 64'(dyg[31:0]) * 64'(dyg[31:0]);
      p10_q  <= (A1_W+32)'(dyg[DYG_W-1:32]) * (A1_W+32)'(dyg[31:0]);
      p11_q  <= (2*A1_W)'(dyg[DYG_W-1:32]) * (2*A1_W)'(dyg[DYG_W-1:32]);
      xx_q   <= 64'(adx6_q) * 64'(adx6_q);
      den7_q <= den6_q;
      np7_q  <= np6_q;

      sq_q   <= SQ_W'({p11_q, p00_q}) + (SQ_W'(p10_q) << 33) + (SQ_W'(xx_q) << 30);
      den8_q <= den7_q;
      np8_q  <= np7_q;
    end
  end

  // --------------------------------------------------------------------------
  // Square root of the squared length
  // --------------------------------------------------------------------------
  mpd_isqrt #(
    .IN_W   (SQ_W),
    .SIDE_W (DEN_W + 1)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (v_q[7]),
    .rad_i  (sq_q),
    .side_i ({den8_q, np8_q}),
    .vld_o  (rt_vld),
    .root_o (root),
    .side_o (rt_side)
  );

  // --------------------------------------------------------------------------
  // Circumference times length, in two halves
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q <= 1'b0;
      m2_vld_q <= 1'b0;
    end else if (en) begin
      m1_vld_q <= rt_vld;
      m2_vld_q <= m1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      mlo_q    <= (CW+32)'(circ_q) * (CW+32)'(root[31:0]);
      mhi_q    <= (CW+32)'(circ_q) * (CW+32)'(root[RT_W-1:32]);
      den_m1_q <= rt_side[DEN_W:1];
      np_m1_q  <= rt_side[0];
      num_q    <= NUM_W'(mlo_q) + (NUM_W'(mhi_q) << 32);
      den_m2_q <= den_m1_q;
      np_m2_q  <= np_m1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Division by the scale polynomial
  // --------------------------------------------------------------------------
  mpd_div #(
    .NUM_W  (NUM_W),
    .DEN_W  (DEN_W),
    .QUO_W  (mpd_pkg::DIST_W),
    .SIDE_W (1)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (m2_vld_q),
    .num_i  (num_q),
    .den_i  (den_m2_q),
    .side_i (np_m2_q),
    .vld_o  (dv_vld),
    .quo_o  (quo),
    .ovf_o  (ovf),
    .side_o (dv_np)
  );

  // --------------------------------------------------------------------------
  // Output buffer
  // --------------------------------------------------------------------------
  always_comb begin
    res.sat     = dv_np | ovf;
    res.dist_mm = res.sat ? mpd_pkg::DIST_MAX : quo;
    pop         = (cnt_q != 2'd0) & m_axis_tready;
    en          = !dv_vld | (cnt_q != 2'd2) | pop;
    push        = dv_vld & en;
    cnt_d       = cnt_q;
    b0_d        = b0_q;
    b1_d        = b1_q;
    unique case ({push, pop})
      2'b11: begin
        if (cnt_q == 2'd1) begin
          b0_d = res;
        end else begin
          b0_d = b1_q;
          b1_d = res;
        end
      end
      2'b10: begin
        if (cnt_q == 2'd0) begin
          b0_d = res;
        end else begin
          b1_d = res;
        end
        cnt_d = cnt_q + 2'd1;
      end
      2'b01: begin
        b0_d  = b1_q;
        cnt_d = cnt_q - 2'd1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    b0_q <= b0_d;
    b1_q <= b1_d;
  end

  assign m_axis_tvalid = (cnt_q != 2'd0);
  assign m_axis_tdata  = mpd_pkg::OUT_DATA_W'(b0_q.dist_mm);
  assign m_axis_tuser  = b0_q.sat;

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the mercator point distance block. Point pairs are
// streamed in with random gaps, every result is compared against a bit-exact
// fixed-point predictor, and the coefficient registers are changed between
// phases while the pipeline is empty.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import mpd_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [127:0]          s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic                  m_axis_tuser;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [CIRC_W-1:0]        circ_mm = CIRC_RST;
  logic signed [COEF_W-1:0] sc0 = SCALE_C0_RST, sc2 = SCALE_C2_RST, sc4 = SCALE_C4_RST;
  logic signed [COEF_W-1:0] vc0 = VERT_C0_RST, vc2 = VERT_C2_RST, vc4 = VERT_C4_RST;

  logic [127:0] pending_pairs[$];
  result_t      expected_dist[$];
  int           errors = 0;
  int           results_seen = 0;
  int           saturated_seen = 0;
  int           cycle_count = 0;
  logic         in_fire = 1'b0;
  logic         quiet;

  mercator_point_distance u_top (
    .clk_i, .rst_ni, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser,
    .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  assign quiet = (cycle_count >= 2000) && (cycle_count < 4000);

  function automatic longint poly_eval(logic signed [31:0] c0, logic signed [31:0] c2,
                                       logic signed [31:0] c4, longint z2, longint z4);
    longint t2, t4;
    t2 = longint'(c2) * z2;
    t4 = longint'(c4) * z4;
    return longint'(c0) + (t2 >>> 24) + (t4 >>> 24);
  endfunction

  function automatic result_t predict_distance(logic [127:0] pair);
    logic [31:0]  x1, y1, x2, y2, adx, ady;
    logic [32:0]  ysum, azh;
    longint       za, z2, z4, vf, sf;
    logic [63:0]  avf, dxg, dyg, root, trial;
    logic [127:0] sq, num, den, quo, prod;
    result_t      res;
    x1 = pair[31:0];
    y1 = pair[63:32];
    x2 = pair[95:64];
    y2 = pair[127:96];
    adx = (x1 >= x2) ? x1 - x2 : x2 - x1;
    ady = (y1 >= y2) ? y1 - y2 : y2 - y1;
    ysum = {1'b0, y1} + {1'b0, y2};
    azh = (ysum >= 33'h1_0000_0000) ? ysum - 33'h1_0000_0000 : 33'h1_0000_0000 - ysum;
    za = longint'(azh >> 9);
    z2 = (za * za) >>> 24;
    z4 = (z2 * z2) >>> 24;
    vf = poly_eval(vc0, vc2, vc4, z2, z4);
    sf = poly_eval(sc0, sc2, sc4, z2, z4);
    if (sf <= 0) begin
      res.dist_mm = DIST_MAX;
      res.sat = 1'b1;
      return res;
    end
    avf = (vf >= 0) ? 64'(vf) : 64'(-vf);
    dxg = {32'd0, adx} << 15;
    prod = {96'd0, ady} * {64'd0, avf};
    dyg = 64'(prod >> 9);
    sq = {64'd0, dxg} * {64'd0, dxg} + {64'd0, dyg} * {64'd0, dyg};
    root = '0;
    for (int b = 63; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if ({64'd0, trial} * {64'd0, trial} <= sq) root = trial;
    end
    num = {92'd0, circ_mm} * {64'd0, root};
    den = {64'd0, 64'(sf)} << 23;
    quo = num / den;
    if (quo > {91'd0, DIST_MAX}) begin
      res.dist_mm = DIST_MAX;
      res.sat = 1'b1;
    end else begin
      res.dist_mm = quo[DIST_W-1:0];
      res.sat = 1'b0;
    end
    return res;
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!s_axis_tvalid || in_fire) begin
        if (pending_pairs.size() > 0 && (quiet || $urandom_range(99) >= 6)) begin
          s_axis_tdata <= pending_pairs.pop_front();
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= quiet || ($urandom_range(99) >= 6);
    end
  end

  always @(posedge clk_i) begin
    result_t got, want;
    cycle_count <= cycle_count + 1;
    in_fire <= s_axis_tvalid && s_axis_tready;
    if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_CIRCUMFERENCE: circ_mm = cfg_data_i;
        REG_SCALE_C0:      sc0 = cfg_data_i[31:0];
        REG_SCALE_C2:      sc2 = cfg_data_i[31:0];
        REG_SCALE_C4:      sc4 = cfg_data_i[31:0];
        REG_VERT_C0:       vc0 = cfg_data_i[31:0];
        REG_VERT_C2:       vc2 = cfg_data_i[31:0];
        REG_VERT_C4:       vc4 = cfg_data_i[31:0];
        default: ;
      endcase
    end
    if (s_axis_tvalid && s_axis_tready) expected_dist.push_back(predict_distance(s_axis_tdata));
    if (m_axis_tvalid && m_axis_tready) begin
      got.dist_mm = m_axis_tdata[DIST_W-1:0];
      got.sat = m_axis_tuser;
      results_seen++;
      if (got.sat) saturated_seen++;
      if (expected_dist.size() == 0) begin
        $display("%0t: unexpected transaction, actual dist=%0d sat=%0b",
                 $time, got.dist_mm, got.sat);
        errors++;
      end else begin
        want = expected_dist.pop_front();
        if (got.dist_mm !== want.dist_mm) begin
          $display("%0t: distance mismatch, expected %0d actual %0d",
                   $time, want.dist_mm, got.dist_mm);
          errors++;
        end
        if (got.sat !== want.sat) begin
          $display("%0t: saturation flag mismatch, expected %0b actual %0b",
                   $time, want.sat, got.sat);
          errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = val;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic push_pair(logic [31:0] x1, logic [31:0] y1, logic [31:0] x2,
                           logic [31:0] y2);
    pending_pairs.push_back({y2, x2, y1, x1});
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  task automatic push_random(int count);
    logic [31:0] x1, y1, x2, y2;
    repeat (count) begin
      x1 = $urandom;
      y1 = $urandom;
      case ($urandom_range(3))
        0: begin x2 = $urandom; y2 = $urandom; end
        1: begin
          x2 = x1 + $urandom_range(65535);
          y2 = y1 - $urandom_range(65535);
        end
        2: begin x1 = rand_coord(); y1 = rand_coord(); x2 = rand_coord(); y2 = rand_coord(); end
        default: begin
          y2 = 32'hFFFF_FFFF - y1 + $urandom_range(4095);
          x2 = $urandom;
        end
      endcase
      push_pair(x1, y1, x2, y2);
    end
  endtask

  task automatic drain();
    wait (pending_pairs.size() == 0 && !s_axis_tvalid && expected_dist.size() == 0);
    repeat (200) @(posedge clk_i);
  endtask

  task automatic write_scale(logic [31:0] c0, logic [31:0] c2, logic [31:0] c4);
    write_reg(REG_SCALE_C0, {4'd0, c0});
    write_reg(REG_SCALE_C2, {4'd0, c2});
    write_reg(REG_SCALE_C4, {4'd0, c4});
  endtask

  task automatic write_vert(logic [31:0] c0, logic [31:0] c2, logic [31:0] c4);
    write_reg(REG_VERT_C0, {4'd0, c0});
    write_reg(REG_VERT_C2, {4'd0, c2});
    write_reg(REG_VERT_C4, {4'd0, c4});
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    push_pair(32'd0, 32'd0, 32'd0, 32'd0);
    push_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(32'hFFFF_FFFF, 32'd0, 32'd0, 32'hFFFF_FFFF);
    push_pair(32'd0, 32'h8000_0000, 32'hFFFF_FFFF, 32'h8000_0000);
    push_pair(32'h1234_5678, 32'h0000_0000, 32'h1234_5678, 32'hFFFF_FFFF);
    push_pair(32'h4000_0000, 32'h7FFF_FFFF, 32'h4000_0001, 32'h8000_0001);
    push_pair(32'd5, 32'd0, 32'd9, 32'd0);
    push_pair(32'hAAAA_AAAA, 32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA);
    push_random(250);
    drain();

    // Tiny divisor with the largest circumference forces overflow; the
    // stretch is negative so only its magnitude may count.
    write_reg(REG_CIRCUMFERENCE, 36'hF_FFFF_FFFF);
    write_scale(32'd1, 32'd0, 32'd0);
    write_vert(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000);
    push_pair(32'd0, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    push_pair(32'd0, 32'h8000_0000, 32'd0, 32'h8000_0000);
    push_random(50);
    drain();

    write_scale(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    write_reg(REG_CIRCUMFERENCE, 36'd0);
    push_pair(32'd0, 32'h8000_0000, 32'd7, 32'h8000_0000);
    push_random(40);
    drain();

    repeat (4) begin
      write_reg(REG_CIRCUMFERENCE, {$urandom, 4'($urandom)});
      write_scale({1'b0, 31'($urandom)}, $urandom, $urandom);
      write_vert($urandom, $urandom, $urandom);
      push_random(40);
      drain();
    end

    write_scale(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
    write_vert(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    push_random(40);
    drain();

    write_reg(REG_CIRCUMFERENCE, CIRC_RST);
    write_scale(SCALE_C0_RST, SCALE_C2_RST, SCALE_C4_RST);
    write_vert(VERT_C0_RST, VERT_C2_RST, VERT_C4_RST);
    write_reg(REG_UNUSED, 36'hF_FFFF_FFFF);
    push_random(60);
    drain();

    if (expected_dist.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, expected_dist.size());
      errors++;
    end
    $display("Checked %0d distance results, %0d of them saturated, over eight",
             results_seen, saturated_seen);
    $display("coefficient settings including overflow and non-positive divisors.");
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("Run timed out with %0d results outstanding.", expected_dist.size());
    $display("tb_top: errors");
    $finish;
  end

endmodule

/* files.f */
hw/rtl/mpd_pkg.sv
hw/rtl/mpd_isqrt.sv
hw/rtl/mpd_div.sv
hw/rtl/mercator_point_distance.sv
bench/tb_top.sv
